// ===== design/smx_pkg.sv =====
// Shared widths, opcode and error codes, and the decoded command type of the stack machine.
package smx_pkg;

  localparam int unsigned OPCODE_W    = 4;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned LINE_W      = 16;
  localparam int unsigned ERR_W       = 2;
  localparam int unsigned DEPTH_W     = 5;
  localparam int unsigned NEED_W      = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_NOP   = 4'd0,
    OP_PUSH  = 4'd1,
    OP_POP   = 4'd2,
    OP_ADD   = 4'd3,
    OP_IFEQ  = 4'd4,
    OP_JUMP  = 4'd5,
    OP_PRINT = 4'd6,
    OP_DUP   = 4'd7,
    OP_SWAP  = 4'd8,
    OP_ROLL  = 4'd9
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_HALT  = 2'd3
  } err_t;

  // Decoded instruction as it travels from the front end to the execute unit
  typedef struct packed {
    op_t                op;
    logic [NEED_W-1:0]  need;    // entries the instruction must find on the stack
    logic               grows;   // instruction adds an entry
    logic [VALUE_W-1:0] value;
    logic [LINE_W-1:0]  target;
  } cmd_t;

endpackage

// ===== design/smx_if.sv =====
// Valid/ready channel interfaces for instruction items and result items.
interface smx_in_if
  import smx_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic signed [VALUE_W-1:0] push_value;
  logic [LINE_W-1:0]         target_line;

  modport source (output valid, opcode, push_value, target_line, input ready);
  modport sink   (input valid, opcode, push_value, target_line, output ready);
endinterface

interface smx_out_if
  import smx_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [LINE_W-1:0]         next_line;
  logic                      print_valid;
  logic signed [VALUE_W-1:0] print_value;
  logic [ERR_W-1:0]          error_code;
  logic [DEPTH_W-1:0]        depth_now;

  modport source (output valid, next_line, print_valid, print_value, error_code, depth_now,
                  input ready);
  modport sink   (input valid, next_line, print_valid, print_value, error_code, depth_now,
                  output ready);
endinterface

// ===== design/smx_front.sv =====
// Front end: accepts instruction items and classifies them into decoded commands.
module smx_front
  import smx_pkg::*;
(
  smx_in_if.sink     in_ch,
  output logic       q_valid,
  input  logic       q_ready,
  output cmd_t       q_cmd
);

  // pass the handshake straight to the queue
  assign q_valid     = in_ch.valid;
  assign in_ch.ready = q_ready;

  // classify opcode: stack demand and growth; unused codes become nop
  always_comb begin
    q_cmd        = '0;
    q_cmd.op     = OP_NOP;
    q_cmd.value  = in_ch.push_value;
    q_cmd.target = in_ch.target_line;
    case (in_ch.opcode)
      OP_PUSH: begin
        q_cmd.op    = OP_PUSH;
        q_cmd.grows = 1'b1;
      end
      OP_POP: begin
        q_cmd.op   = OP_POP;
        q_cmd.need = NEED_W'(1);
      end
      OP_ADD: begin
        q_cmd.op   = OP_ADD;
        q_cmd.need = NEED_W'(2);
      end
      OP_IFEQ: begin
        q_cmd.op   = OP_IFEQ;
        q_cmd.need = NEED_W'(1);
      end
      OP_JUMP: begin
        q_cmd.op = OP_JUMP;
      end
      OP_PRINT: begin
        q_cmd.op   = OP_PRINT;
        q_cmd.need = NEED_W'(1);
      end
      OP_DUP: begin
        q_cmd.op    = OP_DUP;
        q_cmd.need  = NEED_W'(1);
        q_cmd.grows = 1'b1;
      end
      OP_SWAP: begin
        q_cmd.op   = OP_SWAP;
        q_cmd.need = NEED_W'(2);
      end
      OP_ROLL: begin
        q_cmd.op   = OP_ROLL;
        q_cmd.need = NEED_W'(1);
      end
      default: begin
        q_cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

// ===== design/smx_queue.sv =====
// Two-entry command queue between the front end and the execute unit.
module smx_queue
  import smx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic w_valid,
  output logic w_ready,
  input  cmd_t w_cmd,
  output logic r_valid,
  input  logic r_ready,
  output cmd_t r_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign w_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign r_valid = (fill != '0);
  assign r_cmd   = slots[rd_ptr];
  assign push    = w_valid && w_ready;
  assign pop     = r_valid && r_ready;

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  // hold queued commands
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= w_cmd;
  end

endmodule

// ===== design/smx_back.sv =====
// Execute unit: stack state, top-two word registers, ring memory and result register.
module smx_back
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned LINE_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  smx_out_if.source  out_ch
);

  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned LW  = LINE_BITS + LINE_W;
  localparam int unsigned DXW = CW + DEPTH_W;

  // architectural state
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        base, base_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic                 halted, halted_next;
  logic [VALUE_W-1:0]   tos, tos_next;
  logic [VALUE_W-1:0]   sos, sos_next;

  // ring memory holds every entry below the top two
  logic [VALUE_W-1:0]   mem [STACK_DEPTH];
  logic [VALUE_W-1:0]   rd_data;
  logic                 byp_valid;
  logic [VALUE_W-1:0]   byp_data;
  logic [VALUE_W-1:0]   third;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [VALUE_W-1:0]   wdata;
  logic [AW-1:0]        raddr;

  // slot arithmetic
  logic [AW:0]          spill_sum;
  logic [AW-1:0]        spill_slot;
  logic [AW-1:0]        roll_slot;
  logic [AW:0]          rd_sum;

  logic                 fire;
  logic                 full;
  logic [LINE_BITS-1:0] line_inc;
  logic [LW-1:0]        tgt_ext;
  logic [LINE_BITS-1:0] tgt;
  logic [LW-1:0]        nl_ext;
  logic [DXW-1:0]       dep_ext;
  err_t                 err;
  logic                 pvalid;
  logic [VALUE_W-1:0]   pval;

  // result register
  logic                 o_valid;
  logic [LINE_W-1:0]    o_next_line;
  logic                 o_print_valid;
  logic [VALUE_W-1:0]   o_print_value;
  err_t                 o_error;
  logic [DEPTH_W-1:0]   o_depth;

  assign q_ready  = !o_valid || out_ch.ready;
  assign fire     = q_valid && q_ready;
  assign full     = (count == CW'(STACK_DEPTH));
  assign third    = byp_valid ? byp_data : rd_data;
  assign line_inc = line + LINE_BITS'(1);
  assign tgt_ext  = LW'(q_cmd.target);
  assign tgt      = tgt_ext[LINE_BITS-1:0];

  // ring slots: second entry from top, and the slot below the base
  assign spill_sum  = {1'b0, base} + (AW+1)'(count - CW'(2));
  assign spill_slot = (spill_sum >= (AW+1)'(STACK_DEPTH)) ?
                      AW'(spill_sum - (AW+1)'(STACK_DEPTH)) : spill_sum[AW-1:0];
  assign roll_slot  = (base == '0) ? AW'(STACK_DEPTH - 1) : base - AW'(1);

  // execute one instruction
  always_comb begin
    count_next  = count;
    base_next   = base;
    line_next   = line;
    halted_next = halted;
    tos_next    = tos;
    sos_next    = sos;
    err         = ERR_NONE;
    pvalid      = 1'b0;
    pval        = '0;
    we          = 1'b0;
    waddr       = spill_slot;
    wdata       = sos;
    if (fire) begin
      if (halted) begin
        err = ERR_HALT;
      end else if (count < CW'(q_cmd.need)) begin
        err = ERR_UNDER;
      end else if (q_cmd.grows && full) begin
        err = ERR_OVER;
      end else begin
        line_next = line_inc;
        case (q_cmd.op)
          OP_PUSH, OP_DUP: begin
            // spill the second word, shift the top down
            we         = (count > CW'(1));
            sos_next   = tos;
            tos_next   = (q_cmd.op == OP_PUSH) ? q_cmd.value : tos;
            count_next = count + CW'(1);
          end
          OP_POP: begin
            tos_next   = sos;
            sos_next   = third;
            count_next = count - CW'(1);
          end
          OP_ADD: begin
            tos_next   = sos + tos;
            sos_next   = third;
            count_next = count - CW'(1);
          end
          OP_IFEQ: begin
            if (tos != '0) line_next = tgt;
          end
          OP_JUMP: begin
            line_next = tgt;
          end
          OP_PRINT: begin
            pvalid = 1'b1;
            pval   = tos;
          end
          OP_SWAP: begin
            tos_next = sos;
            sos_next = tos;
          end
          OP_ROLL: begin
            // move the top word under the bottom by stepping the base back
            base_next = roll_slot;
            if (count > CW'(1)) begin
              tos_next = sos;
              sos_next = (count > CW'(2)) ? third : tos;
            end
            if (count > CW'(2)) begin
              we    = 1'b1;
              waddr = roll_slot;
              wdata = tos;
            end
          end
          default: begin
          end
        endcase
      end
      if (err == ERR_UNDER || err == ERR_OVER) halted_next = 1'b1;
    end
  end

  // fetch the third word for the state that follows
  assign rd_sum = {1'b0, base_next} + (AW+1)'(count_next - CW'(3));
  always_comb begin
    raddr = '0;
    if (count_next > CW'(2)) begin
      raddr = (rd_sum >= (AW+1)'(STACK_DEPTH)) ?
              AW'(rd_sum - (AW+1)'(STACK_DEPTH)) : rd_sum[AW-1:0];
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  // forward a same-cycle write to the third word
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wdata;
  end

  // update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      base   <= '0;
      line   <= LINE_BITS'(1);
      halted <= 1'b0;
    end else begin
      count  <= count_next;
      base   <= base_next;
      line   <= line_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    sos <= sos_next;
  end

  // result register: load when free or being drained
  assign nl_ext  = LW'(line_next);
  assign dep_ext = DXW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (q_ready) begin
      o_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_next_line   <= nl_ext[LINE_W-1:0];
      o_print_valid <= pvalid;
      o_print_value <= pval;
      o_error       <= err;
      o_depth       <= dep_ext[DEPTH_W-1:0];
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.next_line   = o_next_line;
  assign out_ch.print_valid = o_print_valid;
  assign out_ch.print_value = o_print_value;
  assign out_ch.error_code  = o_error;
  assign out_ch.depth_now   = o_depth;

  // an underflow or overflow halts the machine
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    fire && !halted && (err == ERR_UNDER || err == ERR_OVER) |=> halted)
    else $error("error taken without halting");

  // once halted, stack pointers and line are frozen
  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted && $stable(count) && $stable(base) && $stable(line))
    else $error("state changed while halted");

  // a printed value never comes with an error
  a_print_clean: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_print_valid |-> o_error == ERR_NONE)
    else $error("print reported together with an error");

  // a successful push or dup adds exactly one entry
  a_grow_one: assert property (@(posedge clk) disable iff (rst)
    fire && q_cmd.grows && err == ERR_NONE |=> count == $past(count) + CW'(1))
    else $error("growing instruction did not add one entry");

endmodule

// ===== design/stack_machine_executor_top.sv =====
// Top level of the stack machine executor: front end, command queue and execute unit.
// Each item is one instruction, decoded in the front end; the block returns exactly one
// result item per instruction, in order, and sustains one instruction per clock cycle
// while the result channel is ready. An accepted instruction is registered in the
// command queue and then in the result register. The rate is set by the execute unit,
// which keeps the top two stack words in registers and the third in the registered read
// port of the ring memory, updating all of them in the same cycle. The stack memory has
// no clearing pass; entries are only used after being written. After an underflow or
// overflow the machine reports halted on every later item until reset.
module stack_machine_executor_top
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned LINE_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  smx_in_if.sink     in_ch,
  smx_out_if.source  out_ch
);

  logic q_w_valid;
  logic q_w_ready;
  cmd_t q_w_cmd;
  logic q_r_valid;
  logic q_r_ready;
  cmd_t q_r_cmd;

  smx_front u_front (
    .in_ch   (in_ch),
    .q_valid (q_w_valid),
    .q_ready (q_w_ready),
    .q_cmd   (q_w_cmd)
  );

  smx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .w_valid (q_w_valid),
    .w_ready (q_w_ready),
    .w_cmd   (q_w_cmd),
    .r_valid (q_r_valid),
    .r_ready (q_r_ready),
    .r_cmd   (q_r_cmd)
  );

  smx_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_r_valid),
    .q_ready (q_r_ready),
    .q_cmd   (q_r_cmd),
    .out_ch  (out_ch)
  );

endmodule
